// ===== hw/rtl/tdpg_pkg.sv =====
`default_nettype none

package tdpg_pkg;

	localparam int DATA_W  = 32;
	localparam int IDX_W   = 12;
	localparam int LIMIT_W = 13;

	// request to the shared divider
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_ctl_t;

	// divider status and result
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] quo;
		logic [DATA_W-1:0] rem;
	} div_st_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tdpg_if.sv =====
`default_nettype none

interface tdpg_req_if ();
	logic valid;
	logic ready;
	logic restart;

	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

interface tdpg_res_if import tdpg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] prime;
	logic [IDX_W-1:0]  prime_index;
	logic              done_res;

	modport source(output valid, output prime, output prime_index, output done_res,
		input ready);
	modport sink(input valid, input prime, input prime_index, input done_res,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tdpg_div.sv =====
`default_nettype none

module tdpg_div import tdpg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_ctl_t ctl,
	output div_st_t  st
);

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] divisor_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              fits;

	// restoring division, one quotient bit per cycle, msb first
	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			divisor_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				rem_q     <= '0;
				quo_q     <= ctl.dividend;
				divisor_q <= ctl.divisor;
				cnt_q     <= CNT_W'(DATA_W);
				busy_q    <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], fits};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign st.quo  = quo_q;
	assign st.rem  = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/trial_division_prime_generator.sv =====
// flow: a done answer or prime 2 goes from the start state straight to emit; any other prime
//   takes a bound check and then trial divisions for each tried odd candidate
// throughput: one request at a time, set by the single bit-serial divider
//   and the one read port of the prime store
// reset: candidate 3, bound 0, count 0, prime_limit 4096; the prime store is not cleared
`default_nettype none

module trial_division_prime_generator import tdpg_pkg::*; #(
	parameter int PRIME_STORE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	tdpg_req_if.sink           req,
	tdpg_res_if.source         res
);

	localparam int AW = $clog2(PRIME_STORE);
	localparam int CW = AW + 1;
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_BCHK  = 4'd2;
	localparam logic [3:0] S_BRD   = 4'd3;
	localparam logic [3:0] S_BDIV  = 4'd4;
	localparam logic [3:0] S_LCHK  = 4'd5;
	localparam logic [3:0] S_LRD   = 4'd6;
	localparam logic [3:0] S_LDIV  = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;

	logic [3:0]         state_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [DATA_W-1:0]  cand_q;
	logic [DATA_W-1:0]  p_q;
	logic [AW-1:0]      bound_q;
	logic [AW-1:0]      idx_q;
	logic [CW-1:0]      count_q;

	logic [DATA_W-1:0]  pend_prime_q;
	logic [IDX_W-1:0]   pend_idx_q;
	logic               pend_done_q;
	logic [DATA_W-1:0]  out_prime_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic               out_done_q;
	logic               res_valid_q;

	logic [DATA_W-1:0]  store_mem [PRIME_STORE];
	logic [DATA_W-1:0]  rd_q;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [DATA_W-1:0]  wr_data;

	div_ctl_t           div_ctl;
	div_st_t            div_st;

	logic [LW-1:0]      lim_ext;
	logic [LW-1:0]      store_ext;
	logic [LW-1:0]      eff_limit;
	logic               at_limit;
	logic               bound_lt_count;
	logic               idx_lt_bound;
	logic               req_acc;
	logic               out_free;

	assign lim_ext        = LW'(limit_q);
	assign store_ext      = LW'(PRIME_STORE);
	assign eff_limit      = (lim_ext > store_ext) ? store_ext : lim_ext;
	assign at_limit       = LW'(count_q) >= eff_limit;
	assign bound_lt_count = CW'(bound_q) < count_q;
	assign idx_lt_bound   = idx_q < bound_q;
	assign req_acc        = req.valid && req.ready;
	assign out_free       = !res_valid_q || res.ready;

	assign req.ready = (state_q == S_IDLE);

	// prime store: one read port, one write port
	assign rd_en   = ((state_q == S_BCHK) && bound_lt_count) ||
		((state_q == S_LCHK) && idx_lt_bound);
	assign rd_addr = (state_q == S_BCHK) ? bound_q : idx_q;
	assign wr_en   = ((state_q == S_START) && !at_limit && (count_q == '0)) ||
		((state_q == S_LCHK) && !idx_lt_bound);
	assign wr_data = (state_q == S_START) ? DATA_W'(2) : p_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[count_q[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= store_mem[rd_addr];
		end
	end

	assign div_ctl.start    = (state_q == S_BRD) || (state_q == S_LRD);
	assign div_ctl.dividend = p_q;
	assign div_ctl.divisor  = rd_q;

	tdpg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.st     (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			limit_q      <= LIMIT_RESET;
			cand_q       <= DATA_W'(3);
			p_q          <= '0;
			bound_q      <= '0;
			idx_q        <= '0;
			count_q      <= '0;
			pend_prime_q <= '0;
			pend_idx_q   <= '0;
			pend_done_q  <= 1'b0;
			out_prime_q  <= '0;
			out_idx_q    <= '0;
			out_done_q   <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			// the emit state reloads the output register itself
			if (res_valid_q && res.ready && (state_q != S_EMIT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (req.restart) begin
							cand_q  <= DATA_W'(3);
							bound_q <= '0;
							count_q <= '0;
						end
						state_q <= S_START;
					end
				end
				S_START: begin
					if (at_limit) begin
						pend_prime_q <= '0;
						pend_idx_q   <= '0;
						pend_done_q  <= 1'b1;
						state_q      <= S_EMIT;
					end else if (count_q == '0) begin
						pend_prime_q <= DATA_W'(2);
						pend_idx_q   <= '0;
						pend_done_q  <= 1'b0;
						count_q      <= CW'(1);
						state_q      <= S_EMIT;
					end else begin
						p_q     <= cand_q;
						cand_q  <= cand_q + DATA_W'(2);
						state_q <= S_BCHK;
					end
				end
				S_BCHK: begin
					idx_q <= AW'(1);
					if (bound_lt_count) begin
						state_q <= S_BRD;
					end else begin
						state_q <= S_LCHK;
					end
				end
				S_BRD: begin
					state_q <= S_BDIV;
				end
				S_BDIV: begin
					// d*d <= p exactly when d <= floor(p / d)
					if (div_st.done) begin
						if (rd_q <= div_st.quo) begin
							bound_q <= bound_q + AW'(1);
						end
						state_q <= S_LCHK;
					end
				end
				S_LCHK: begin
					if (idx_lt_bound) begin
						state_q <= S_LRD;
					end else begin
						pend_prime_q <= p_q;
						pend_idx_q   <= IDX_W'(count_q);
						pend_done_q  <= 1'b0;
						count_q      <= count_q + CW'(1);
						state_q      <= S_EMIT;
					end
				end
				S_LRD: begin
					state_q <= S_LDIV;
				end
				S_LDIV: begin
					if (div_st.done) begin
						if ((rd_q != '0) && (div_st.rem == '0)) begin
							// composite, move on to the next odd candidate
							state_q <= S_START;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= S_LCHK;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_prime_q <= pend_prime_q;
						out_idx_q   <= pend_idx_q;
						out_done_q  <= pend_done_q;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid       = res_valid_q;
	assign res.prime       = out_prime_q;
	assign res.prime_index = out_idx_q;
	assign res.done_res    = out_done_q;

	a_bound_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(bound_q) <= count_q)
		else $error("divisor bound passed the prime count");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_st.busy)
		else $error("divider started while busy");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.done_res |-> (res.prime == '0) && (res.prime_index == '0))
		else $error("done result carries a prime");

	a_prime_odd: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.done_res |-> res.prime[0] || (res.prime == DATA_W'(2)))
		else $error("even prime other than two");

endmodule

`default_nettype wire

// ===== dv/tb_trial_division_prime_generator.sv =====
module tb_trial_division_prime_generator;
	import tdpg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRIME_STORE    = 4096;
	localparam int RANDOM_ITEMS   = 115;
	localparam int LONG_HOLD      = 500;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct packed {
		logic [DATA_W-1:0] prime;
		logic [IDX_W-1:0]  prime_index;
		logic              done_res;
	} prime_res_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	tdpg_req_if req_bus ();
	tdpg_res_if res_bus ();

	trial_division_prime_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.res       (res_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state, mirrors the block after reset
	logic [DATA_W-1:0]  found_tab [PRIME_STORE];
	logic [DATA_W-1:0]  cand = 32'd3;
	int unsigned        bound = 0;
	int unsigned        found = 0;
	logic [LIMIT_W-1:0] limit_cfg = 13'd4096;

	bit          restart_queue [$];
	prime_res_t  due_primes [$];
	int          errors = 0;
	bit          hold_request = 1'b0;

	function automatic bit passes_trial(input logic [DATA_W-1:0] p);
		logic [63:0] d;
		int unsigned i;
		if (bound < found) begin
			d = {32'd0, found_tab[bound]};
			if (d * d <= {32'd0, p})
				bound++;
		end
		for (i = 1; i < bound && i < found; i++) begin
			if (found_tab[i] != 0 && (p % found_tab[i]) == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic prime_res_t next_prime(input logic restart);
		int unsigned       cap;
		logic [DATA_W-1:0] p;
		prime_res_t        r;
		cap = (limit_cfg > PRIME_STORE) ? PRIME_STORE : limit_cfg;
		if (restart) begin
			cand  = 32'd3;
			bound = 0;
			found = 0;
		end
		if (found >= cap) begin
			r.prime       = '0;
			r.prime_index = '0;
			r.done_res    = 1'b1;
			return r;
		end
		if (found == 0) begin
			p = 32'd2;
		end else begin
			do begin
				p    = cand;
				cand = cand + 32'd2;
			end while (!passes_trial(p));
		end
		r.prime       = p;
		r.prime_index = found[IDX_W-1:0];
		r.done_res    = 1'b0;
		found_tab[found] = p;
		found++;
		return r;
	endfunction

	// request driver: bursts of random length, random gaps
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid   <= 1'b0;
			req_bus.restart <= 1'b0;
			burst_left = 1;
			gap_left   = 0;
		end else if (!req_bus.valid || req_bus.ready) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				req_bus.valid <= 1'b0;
			end else if (restart_queue.size() != 0) begin
				req_bus.valid   <= 1'b1;
				req_bus.restart <= restart_queue.pop_front();
				burst_left = burst_left - 1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 8);
					gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 300)
						: $urandom_range(0, 3);
				end
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// result monitor and checker, also owns the receiver stall pattern
	prime_res_t want;
	int         hold_left = 0;
	bit         hold_taken = 1'b0;
	int         ready_mode = 0;
	int         mode_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (due_primes.size() == 0) begin
					$display("%0t: unexpected result: expected none, got prime %0d index %0d done %0b",
						$time, res_bus.prime, res_bus.prime_index, res_bus.done_res);
					errors++;
				end else begin
					want = due_primes.pop_front();
					if (res_bus.prime !== want.prime) begin
						$display("%0t: prime mismatch: expected %0d, got %0d",
							$time, want.prime, res_bus.prime);
						errors++;
					end
					if (res_bus.prime_index !== want.prime_index) begin
						$display("%0t: prime_index mismatch: expected %0d, got %0d",
							$time, want.prime_index, res_bus.prime_index);
						errors++;
					end
					if (res_bus.done_res !== want.done_res) begin
						$display("%0t: done_res mismatch: expected %0b, got %0b",
							$time, want.done_res, res_bus.done_res);
						errors++;
					end
				end
			end
			// predict after the pop so the queue order never depends on process order
			if (req_bus.valid && req_bus.ready)
				due_primes.push_back(next_prime(req_bus.restart));

			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				res_bus.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = $urandom_range(0, 2);
					mode_left  = $urandom_range(20, 200);
				end else begin
					mode_left = mode_left - 1;
				end
				case (ready_mode)
					0: begin
						res_bus.ready <= 1'b1;
					end
					1: begin
						res_bus.ready <= 1'($urandom_range(0, 1));
					end
					default: begin
						res_bus.ready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	// watchdog on cycles without any handshake
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic settle();
		do
			@(negedge clk);
		while (restart_queue.size() != 0 || req_bus.valid || due_primes.size() != 0);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		settle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_cfg = value;
		@(negedge clk);
	endtask

	// first request carries the given restart, the rest ask for the next prime
	task automatic enqueue(input int count, input bit first_restart);
		restart_queue.push_back(first_restart);
		for (int i = 1; i < count; i++)
			restart_queue.push_back(1'b0);
	endtask

	initial begin
		int sent;
		int phase_len;
		logic [LIMIT_W-1:0] lim;

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// sequence from the start, then a restart in the middle of a stream
		write_limit(13'd4096);
		enqueue(6, 1'b0);
		enqueue(6, 1'b1);
		// limit of zero answers done even on restart
		write_limit(13'd0);
		enqueue(1, 1'b0);
		enqueue(1, 1'b1);
		// limit of one: prime 2 then done
		write_limit(13'd1);
		enqueue(3, 1'b1);
		// limit above the store acts as the store size
		write_limit(13'd8191);
		enqueue(4, 1'b0);
		// limit dropped below the count already reached
		write_limit(13'd2);
		enqueue(1, 1'b0);
		enqueue(3, 1'b1);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: lim = LIMIT_W'($urandom_range(0, 8191));
				1: lim = 13'd4096;
				2: lim = 13'd8191;
				5: lim = 13'd0;
				default: lim = LIMIT_W'($urandom_range(1, 60));
			endcase
			write_limit(lim);
			phase_len = $urandom_range(8, 25);
			for (int i = 0; i < phase_len; i++)
				restart_queue.push_back($urandom_range(0, 14) == 0);
			sent += phase_len;
			// long receiver hold-off, taken only once (first phase), while its requests are still queued
			hold_request = 1'b1;
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && due_primes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== trial_division_prime_generator.f =====
hw/rtl/tdpg_pkg.sv
hw/rtl/tdpg_if.sv
hw/rtl/tdpg_div.sv
hw/rtl/trial_division_prime_generator.sv
dv/tb_trial_division_prime_generator.sv
